### hw/rtl/pal_pkg.sv
package pal_pkg;

   localparam int CAPACITY   = 128;
   localparam int VALUE_BITS = 32;

   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int TREE_FAN    = 8;
   localparam int TREE_LVLS   = (IDX_W + 2) / 3;
   localparam int TREE_LEAVES = 1 << (3 * TREE_LVLS);
   localparam int TREE_NODES  = TREE_LEAVES / TREE_FAN;
   localparam int LVL_CNT_W   = $clog2(TREE_LVLS + 1);

   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_SEARCH = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BADPOS   = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      idx_type     idx;
      value_type   value;
   } cell_cmd_type;

   typedef struct packed {
      logic      search;
      logic      read;
      value_type key;
      idx_type   target;
      cnt_type   count;
   } lookup_type;

   typedef struct packed {
      logic      hit;
      idx_type   idx;
      value_type data;
   } node_type;

   function automatic value_type to_value(input logic [31:0] word);
      logic [63:0] wide;
      wide = 64'(word);
      return wide[VALUE_BITS-1:0];
   endfunction

   function automatic logic [31:0] from_value(input value_type v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[31:0];
   endfunction

   function automatic logic [15:0] widen16(input logic [CNT_W-1:0] v);
      return 16'(v);
   endfunction

endpackage

### hw/rtl/positional_array_list_core.sv
// Append, insert, delete, unknown opcodes and any request with a bad position answer in
// the cycle after acceptance. Search and read go through a registered 8-way select tree
// of TREE_LVLS levels (3 for 128 entries); their response is registered from its top node.
// Throughput: one request per cycle for list edits while responses are taken; search and
// read hold the input for their tree walk, so no new request is taken until it ends.
// Reset clears the entry count and handshake state; entry data is not cleared.
module positional_array_list_core
   import pal_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_opcode,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_found_position,
   output logic signed [31:0] rsp_read_value,
   output logic [7:0]         rsp_entry_count
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_TREE = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [LVL_CNT_W-1:0] lvl_cnt_ff, lvl_cnt_in;
   cnt_type            count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic [7:0]         found_ff, found_in;
   logic [31:0]        read_ff, read_in;
   lookup_type         look_ff, look_in;

   cell_cmd_type       cmd;
   logic               accept;
   logic               pos_ok;
   logic               is_full;
   logic [15:0]        pos_m1;
   logic               direct;
   logic [1:0]         direct_status;

   value_type          cell_data [CAPACITY];
   logic               cell_hit  [CAPACITY];
   node_type           leaf      [TREE_LEAVES];
   node_type           lvl_in    [TREE_LVLS][TREE_NODES];
   node_type           lvl_ff    [TREE_LVLS][TREE_NODES];
   node_type           top;
   logic [15:0]        found_wide;
   logic [15:0]        count_wide;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign pos_ok    = (req_position != 8'd0) && (16'(req_position) <= widen16(count_ff));
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign pos_m1    = 16'(req_position) - 16'd1;

   // request decode
   always_comb begin
      cmd           = '{op: CELL_HOLD, idx: pos_m1[IDX_W-1:0], value: to_value(req_value)};
      count_in      = count_ff;
      direct        = 1'b1;
      direct_status = ST_OK;
      look_in       = look_ff;
      if (accept) begin
         look_in.search = 1'b0;
         look_in.read   = 1'b0;
         look_in.key    = to_value(req_value);
         look_in.target = pos_m1[IDX_W-1:0];
         look_in.count  = count_ff;
         unique case (req_opcode)
            OP_APPEND: begin
               if (is_full) begin
                  direct_status = ST_FULL;
               end else begin
                  cmd.op   = CELL_APPEND;
                  cmd.idx  = count_ff[IDX_W-1:0];
                  count_in = count_ff + 1'b1;
               end
            end
            OP_INSERT: begin
               if (!pos_ok) begin
                  direct_status = ST_BADPOS;
               end else if (is_full) begin
                  direct_status = ST_FULL;
               end else begin
                  cmd.op   = CELL_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_DELETE: begin
               if (!pos_ok) begin
                  direct_status = ST_BADPOS;
               end else begin
                  cmd.op   = CELL_DELETE;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_SEARCH: begin
               direct         = 1'b0;
               look_in.search = 1'b1;
            end
            OP_READ: begin
               if (!pos_ok) begin
                  direct_status = ST_BADPOS;
               end else begin
                  direct       = 1'b0;
                  look_in.read = 1'b1;
               end
            end
            default: direct_status = ST_OK;
         endcase
      end
   end

   // cell row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type prev_d, next_d;
      if (i == 0) begin : g_first
         assign prev_d = '0;
      end else begin : g_mid_prev
         assign prev_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_d = '0;
      end else begin : g_mid_next
         assign next_d = cell_data[i+1];
      end
      pal_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .cmd        (cmd),
         .look       (look_ff),
         .prev_data  (prev_d),
         .next_data  (next_d),
         .data       (cell_data[i]),
         .hit        (cell_hit[i])
      );
   end

   // leaves, padded to a full tree
   for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_leaf
      if (i < CAPACITY) begin : g_live
         assign leaf[i] = '{hit: cell_hit[i], idx: IDX_W'(i), data: cell_data[i]};
      end else begin : g_pad
         assign leaf[i] = '0;
      end
   end

   // registered select tree
   for (genvar l = 0; l < TREE_LVLS; l++) begin : g_lvl
      for (genvar j = 0; j < TREE_NODES; j++) begin : g_node
         if (j < (TREE_LEAVES >> (3 * (l + 1)))) begin : g_used
            node_type [TREE_FAN-1:0] kids;
            if (l == 0) begin : g_from_leaf
               always_comb begin
                  for (int k = 0; k < TREE_FAN; k++) kids[k] = leaf[TREE_FAN*j + k];
               end
            end else begin : g_from_lvl
               always_comb begin
                  for (int k = 0; k < TREE_FAN; k++) kids[k] = lvl_ff[l-1][TREE_FAN*j + k];
               end
            end
            pal_node u_node (
               .kids (kids),
               .pick (lvl_in[l][j])
            );
         end else begin : g_unused
            assign lvl_in[l][j] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
   end

   assign top        = lvl_ff[TREE_LVLS-1][0];
   assign found_wide = 16'(top.idx) + 16'd1;

   // control and result
   always_comb begin
      state_in     = state_ff;
      lvl_cnt_in   = lvl_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      found_in     = found_ff;
      read_in      = read_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (direct) begin
                  rsp_valid_in = 1'b1;
                  status_in    = direct_status;
                  found_in     = 8'd0;
                  read_in      = 32'd0;
               end else begin
                  state_in   = S_TREE;
                  lvl_cnt_in = '0;
               end
            end
         end
         S_TREE: begin
            if (lvl_cnt_ff == LVL_CNT_W'(TREE_LVLS)) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (look_ff.search) begin
                  status_in = top.hit ? ST_OK : ST_NOTFOUND;
                  found_in  = top.hit ? found_wide[7:0] : 8'd0;
                  read_in   = 32'd0;
               end else begin
                  status_in = ST_OK;
                  found_in  = 8'd0;
                  read_in   = from_value(top.data);
               end
            end else begin
               lvl_cnt_in = lvl_cnt_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_cnt_ff   <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_cnt_ff   <= lvl_cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      found_ff  <= found_in;
      read_ff   <= read_in;
      look_ff   <= look_in;
   end

   assign count_wide         = widen16(count_ff);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = found_ff;
   assign rsp_read_value     = read_ff;
   assign rsp_entry_count    = count_wide[7:0];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count beyond capacity");

   a_tree_blocks_input: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TREE |-> !req_ready)
      else $error("request taken during tree walk");

   a_tree_no_pending_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TREE |-> !rsp_valid_ff)
      else $error("response pending during tree walk");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_FULL |-> count_ff == CNT_W'(CAPACITY))
      else $error("full reported on a list with room");

   a_edit_moves_count: assert property (@(posedge clock) disable iff (reset)
      cmd.op == CELL_DELETE |=> count_ff == $past(count_ff) - 1'b1)
      else $error("delete did not shrink the list");

endmodule

### hw/rtl/pal_cell.sv
module pal_cell
   import pal_pkg::*;
(
   input  logic         clock,
   input  idx_type      cell_index,
   input  cell_cmd_type cmd,
   input  lookup_type   look,
   input  value_type    prev_data,
   input  value_type    next_data,
   output value_type    data,
   output logic         hit
);

   value_type data_ff;
   value_type data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_APPEND: begin
            if (cell_index == cmd.idx) data_in = cmd.value;
         end
         CELL_INSERT: begin
            if (cell_index == cmd.idx) data_in = cmd.value;
            else if (cell_index > cmd.idx) data_in = prev_data;
         end
         CELL_DELETE: begin
            if (cell_index >= cmd.idx) data_in = next_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // only live entries take part in a search
   always_comb begin
      hit = 1'b0;
      if (look.search)
         hit = (data_ff == look.key) && (16'(cell_index) < widen16(look.count));
      else if (look.read)
         hit = (cell_index == look.target);
   end

   assign data = data_ff;

endmodule

### hw/rtl/pal_node.sv
module pal_node
   import pal_pkg::*;
(
   input  node_type [TREE_FAN-1:0] kids,
   output node_type                pick
);

   // lowest-numbered hit wins
   always_comb begin
      pick = '0;
      for (int k = TREE_FAN - 1; k >= 0; k--) begin
         if (kids[k].hit) pick = kids[k];
      end
   end

endmodule
